@@ design/mefd_pkg.sv @@
// -----------------------------------------------------------------------------
// Multi-turn encoder feedback decoder package
// Widths, scaling constants and shared types for the feedback decoder.
// -----------------------------------------------------------------------------
package mefd_pkg;

	localparam int NUM_MOTORS  = 7;
	localparam int MOTOR_W     = 3;
	localparam int ANGLE_W     = 16;
	localparam int SPEED_W     = 16;
	localparam int CURRENT_W   = 16;
	localparam int TEMP_W      = 8;
	localparam int TURN_W      = 16;
	localparam int OFFSET_W    = 28;
	localparam int OFFSET_REGS = 4;
	localparam int CFG_IDX_W   = 2;

	localparam int POS_W       = 30;
	localparam int POS_RAD_W   = 36;
	localparam int SPD_RAD_W   = 29;
	localparam int POWER_W     = 30;

	localparam int JUMP_LIMIT  = 4000;
	localparam int COUNT_SHIFT = 13;

	localparam logic signed [TURN_W-1:0] TURN_MAX = 16'sh7FFF;
	localparam logic signed [TURN_W-1:0] TURN_MIN = 16'sh8000;

	// Serial multiplier: a signed multiplier operand taken two bits per cycle
	// against a signed multiplicand held in parallel.
	localparam int MUL_W      = 32;
	localparam int MUL_DIGITS = MUL_W / 2;
	localparam int MUL_CNT_W  = $clog2(MUL_DIGITS);
	localparam int MUL_C_W    = 33;
	localparam int MUL_ACC_W  = MUL_C_W + 3;
	localparam int MUL_PROD_W = 2 * MUL_W;

	localparam logic signed [MUL_C_W-1:0] PI_Q28  = 33'sd843314842;
	localparam logic signed [MUL_C_W-1:0] SPD_Q32 = 33'sd449767901;
	localparam logic signed [MUL_C_W-1:0] PWR_Q48 = 33'sd3999336307;

	localparam int POS_RAD_LSB = 24;
	localparam int SPD_RAD_LSB = 16;
	localparam int POWER_LSB   = 32;

	typedef struct packed {
		logic                       en;
		logic [CFG_IDX_W-1:0]       index;
		logic signed [OFFSET_W-1:0] data;
	} cfg_wr_t;

endpackage

@@ design/mefd_frame_if.sv @@
// -----------------------------------------------------------------------------
// Feedback frame channel
// Valid/ready channel carrying one decoded motor feedback word.
// -----------------------------------------------------------------------------
interface mefd_frame_if import mefd_pkg::*;;

	logic                        valid;
	logic                        ready;
	logic [MOTOR_W-1:0]          motor_index;
	logic [ANGLE_W-1:0]          angle_raw;
	logic signed [SPEED_W-1:0]   speed_raw;
	logic signed [CURRENT_W-1:0] current_raw;
	logic [TEMP_W-1:0]           temperature_raw;

	modport source (
		output valid, motor_index, angle_raw, speed_raw, current_raw, temperature_raw,
		input  ready
	);

	modport sink (
		input  valid, motor_index, angle_raw, speed_raw, current_raw, temperature_raw,
		output ready
	);

endinterface

@@ design/mefd_result_if.sv @@
// -----------------------------------------------------------------------------
// Decoded result channel
// Valid/ready channel carrying one decoded position, speed and power word.
// -----------------------------------------------------------------------------
interface mefd_result_if import mefd_pkg::*;;

	logic                        valid;
	logic                        ready;
	logic [MOTOR_W-1:0]          motor_id_out;
	logic signed [POS_W-1:0]     position_counts;
	logic signed [POS_RAD_W-1:0] position_rad_q16;
	logic signed [SPD_RAD_W-1:0] speed_rad_q16;
	logic signed [CURRENT_W-1:0] current_out;
	logic [TEMP_W-1:0]           temperature_out;
	logic [POWER_W-1:0]          power_q16;

	modport source (
		output valid, motor_id_out, position_counts, position_rad_q16, speed_rad_q16,
		       current_out, temperature_out, power_q16,
		input  ready
	);

	modport sink (
		input  valid, motor_id_out, position_counts, position_rad_q16, speed_rad_q16,
		       current_out, temperature_out, power_q16,
		output ready
	);

endinterface

@@ design/mefd_smul.sv @@
// -----------------------------------------------------------------------------
// Serial multiplier
// Radix-4 serial-parallel signed multiplier: the multiplier operand shifts out
// two bits per cycle, the low product bits shift into a register.
// -----------------------------------------------------------------------------
module mefd_smul import mefd_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic signed [MUL_W-1:0]      x,
	input  logic signed [MUL_C_W-1:0]    c,
	output logic                         busy,
	output logic signed [MUL_PROD_W-1:0] product
);

	logic                        run_q;
	logic [MUL_CNT_W-1:0]        cnt_q;
	logic [MUL_W-1:0]            x_q;
	logic signed [MUL_C_W-1:0]   c_q;
	logic signed [MUL_ACC_W-1:0] c3_q;
	logic signed [MUL_ACC_W-1:0] acc_q;
	logic [MUL_W-1:0]            lo_q;

	logic                        last;
	logic                        neg;
	logic signed [MUL_ACC_W-1:0] c_ext;
	logic signed [MUL_ACC_W-1:0] m;
	logic signed [MUL_ACC_W-1:0] sum;

	// The top digit carries the sign weight of the operand's top bit.
	always_comb begin
		last  = (cnt_q == MUL_CNT_W'(MUL_DIGITS - 1));
		neg   = last && x_q[1];
		c_ext = MUL_ACC_W'(c_q);
		case (x_q[1:0])
			2'b00: m = '0;
			2'b01: m = c_ext;
			2'b10: m = c_ext <<< 1;
			2'b11: m = neg ? c_ext : c3_q;
			default: m = '0;
		endcase
		sum = neg ? (acc_q - m) : (acc_q + m);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			cnt_q <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + MUL_CNT_W'(1);
			if (last) begin
				run_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			c_q   <= c;
			c3_q  <= MUL_ACC_W'(c) + (MUL_ACC_W'(c) <<< 1);
			acc_q <= '0;
			lo_q  <= '0;
		end else if (run_q) begin
			x_q   <= x_q >> 2;
			acc_q <= sum >>> 2;
			lo_q  <= {sum[1:0], lo_q[MUL_W-1:2]};
		end
	end

	assign busy    = run_q;
	assign product = {acc_q[MUL_W-1:0], lo_q};

endmodule

@@ design/mefd_track.sv @@
// -----------------------------------------------------------------------------
// Turn tracker
// Keeps the per-motor angle history and turn count and the zero offsets of
// motors 0 to 3, and forms the multi-turn position in raw counts.
// -----------------------------------------------------------------------------
module mefd_track import mefd_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  cfg_wr_t                 cfg,
	input  logic                    take,
	input  logic [MOTOR_W-1:0]      motor_index,
	input  logic [ANGLE_W-1:0]      angle_raw,
	output logic signed [POS_W-1:0] pos
);

	logic [ANGLE_W-1:0]         last_angle_q [NUM_MOTORS];
	logic signed [TURN_W-1:0]   turn_q [NUM_MOTORS];
	logic [NUM_MOTORS-1:0]      seen_q;
	logic signed [OFFSET_W-1:0] offset_q [OFFSET_REGS];

	logic signed [TURN_W-1:0]   turn_s1;
	logic [ANGLE_W-1:0]         angle_s1;
	logic signed [OFFSET_W-1:0] offset_s1;
	logic                       in_range_s1;
	logic signed [POS_W-1:0]    pos_s2;

	logic                       in_range;
	logic [MOTOR_W-1:0]         rd_idx;
	logic signed [ANGLE_W:0]    diff;
	logic                       jump_dn;
	logic                       jump_up;
	logic signed [TURN_W-1:0]   turn_cur;
	logic signed [TURN_W-1:0]   turn_new;
	logic signed [OFFSET_W-1:0] offset_sel;

	always_comb begin
		in_range = (32'(motor_index) < NUM_MOTORS);
		rd_idx   = in_range ? motor_index : '0;
		diff     = $signed({1'b0, angle_raw}) - $signed({1'b0, last_angle_q[rd_idx]});
		jump_dn  = seen_q[rd_idx] && (diff > JUMP_LIMIT);
		jump_up  = seen_q[rd_idx] && (diff < -JUMP_LIMIT);
		turn_cur = turn_q[rd_idx];
		turn_new = turn_cur;
		if (jump_dn && (turn_cur != TURN_MIN)) begin
			turn_new = turn_cur - TURN_W'(1);
		end else if (jump_up && (turn_cur != TURN_MAX)) begin
			turn_new = turn_cur + TURN_W'(1);
		end
		if (in_range && (32'(motor_index) < OFFSET_REGS)) begin
			offset_sel = offset_q[motor_index[CFG_IDX_W-1:0]];
		end else begin
			offset_sel = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_MOTORS; i++) begin
				last_angle_q[i] <= '0;
				turn_q[i]       <= '0;
			end
			seen_q <= '0;
			for (int i = 0; i < OFFSET_REGS; i++) begin
				offset_q[i] <= '0;
			end
		end else begin
			if (cfg.en) begin
				offset_q[cfg.index] <= cfg.data;
			end
			if (take && in_range) begin
				last_angle_q[rd_idx] <= angle_raw;
				turn_q[rd_idx]       <= turn_new;
				seen_q[rd_idx]       <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			turn_s1     <= turn_new;
			angle_s1    <= angle_raw;
			offset_s1   <= offset_sel;
			in_range_s1 <= in_range;
		end
		if (in_range_s1) begin
			pos_s2 <= (POS_W'(turn_s1) <<< COUNT_SHIFT) + $signed(POS_W'(angle_s1))
				- POS_W'(offset_s1);
		end else begin
			pos_s2 <= '0;
		end
	end

	assign pos = pos_s2;

endmodule

@@ design/multiturn_encoder_feedback_decoder_core.sv @@
// -----------------------------------------------------------------------------
// Multi-turn encoder feedback decoder
// Unwraps motor angle feedback into multi-turn position and scales position,
// speed and power into Q.16 fixed point.
// -----------------------------------------------------------------------------
// Usage: feedback words enter on the frame channel and decoded words leave on
// the result channel, both valid/ready. The zero offsets of motors 0 to 3 are
// written through wr_en, wr_index and wr_data while the block is idle; the
// user must keep to this, as the block itself does not enforce it. A word
// passes the tracker registers, then the position, speed and speed-current
// products share a first pass through the radix-4 serial multipliers, and the
// power product needs a second pass; no new word is taken until it is done.
// The result sits in an output register, so a new word is accepted while the
// previous result waits. If the receiver stalls, the next word runs through the
// multipliers and then waits until the output register is free.
// Reset clears the turn counts, the seen flags, the stored angles and the
// zero offsets, and empties the output register.
// -----------------------------------------------------------------------------
module multiturn_encoder_feedback_decoder_core import mefd_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [CFG_IDX_W-1:0]       wr_index,
	input  logic [OFFSET_W-1:0]        wr_data,
	mefd_frame_if.sink                 frame,
	mefd_result_if.source              result
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_POS   = 3'd1;
	localparam logic [2:0] S_START = 3'd2;
	localparam logic [2:0] S_MUL1  = 3'd3;
	localparam logic [2:0] S_MUL2  = 3'd4;

	logic [2:0]                  state_q;
	logic                        take;
	logic                        start_a;
	logic                        start_b;
	logic                        res_load;
	cfg_wr_t                     cfg;

	logic [MOTOR_W-1:0]          idx_q;
	logic signed [SPEED_W-1:0]   speed_q;
	logic signed [CURRENT_W-1:0] current_q;
	logic [TEMP_W-1:0]           temp_q;

	logic signed [POS_W-1:0]      pos;
	logic                         pos_busy;
	logic                         spd_busy;
	logic                         pwr_busy;
	logic signed [MUL_PROD_W-1:0] pos_prod;
	logic signed [MUL_PROD_W-1:0] spd_prod;
	logic signed [MUL_PROD_W-1:0] pwr_prod;
	logic signed [MUL_W-1:0]      pwr_x;
	logic signed [MUL_C_W-1:0]    pwr_c;
	logic signed [MUL_W-1:0]      sc_prod;
	logic signed [MUL_W-1:0]      mag;

	logic                        out_valid_q;
	logic [MOTOR_W-1:0]          out_idx_q;
	logic signed [POS_W-1:0]     out_pos_q;
	logic signed [POS_RAD_W-1:0] out_pos_rad_q;
	logic signed [SPD_RAD_W-1:0] out_spd_q;
	logic signed [CURRENT_W-1:0] out_cur_q;
	logic [TEMP_W-1:0]           out_temp_q;
	logic [POWER_W-1:0]          out_pwr_q;

	assign cfg.en    = wr_en;
	assign cfg.index = wr_index;
	assign cfg.data  = $signed(wr_data);

	assign frame.ready = (state_q == S_IDLE);
	assign take        = frame.valid && frame.ready;
	assign start_a     = (state_q == S_START);
	assign start_b     = (state_q == S_MUL1) && !(pos_busy || spd_busy || pwr_busy);
	assign res_load    = (state_q == S_MUL2) && !pwr_busy && (!out_valid_q || result.ready);

	// The speed-current product is at most 2^30 in magnitude, so its absolute
	// value fits the multiplier operand as a positive number.
	always_comb begin
		sc_prod = pwr_prod[MUL_W-1:0];
		mag     = sc_prod[MUL_W-1] ? -sc_prod : sc_prod;
		pwr_x   = start_a ? MUL_W'(current_q) : mag;
		pwr_c   = start_a ? MUL_C_W'(speed_q) : PWR_Q48;
	end

	mefd_track u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.take        (take),
		.motor_index (frame.motor_index),
		.angle_raw   (frame.angle_raw),
		.pos         (pos)
	);

	mefd_smul u_pos_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_a),
		.x       (MUL_W'(pos)),
		.c       (PI_Q28),
		.busy    (pos_busy),
		.product (pos_prod)
	);

	mefd_smul u_spd_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_a),
		.x       (MUL_W'(speed_q)),
		.c       (SPD_Q32),
		.busy    (spd_busy),
		.product (spd_prod)
	);

	mefd_smul u_pwr_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start_a || start_b),
		.x       (pwr_x),
		.c       (pwr_c),
		.busy    (pwr_busy),
		.product (pwr_prod)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take) begin
						state_q <= S_POS;
					end
				end
				S_POS: begin
					state_q <= S_START;
				end
				S_START: begin
					state_q <= S_MUL1;
				end
				S_MUL1: begin
					if (start_b) begin
						state_q <= S_MUL2;
					end
				end
				S_MUL2: begin
					if (res_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			idx_q     <= frame.motor_index;
			speed_q   <= frame.speed_raw;
			current_q <= frame.current_raw;
			temp_q    <= frame.temperature_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_idx_q     <= idx_q;
			out_pos_q     <= pos;
			out_pos_rad_q <= pos_prod[POS_RAD_LSB +: POS_RAD_W];
			out_spd_q     <= spd_prod[SPD_RAD_LSB +: SPD_RAD_W];
			out_cur_q     <= current_q;
			out_temp_q    <= temp_q;
			out_pwr_q     <= pwr_prod[POWER_LSB +: POWER_W];
		end
	end

	assign result.valid            = out_valid_q;
	assign result.motor_id_out     = out_idx_q;
	assign result.position_counts  = out_pos_q;
	assign result.position_rad_q16 = out_pos_rad_q;
	assign result.speed_rad_q16    = out_spd_q;
	assign result.current_out      = out_cur_q;
	assign result.temperature_out  = out_temp_q;
	assign result.power_q16        = out_pwr_q;

	// A new word only enters once every multiplier pass has finished.
	a_take_idle: assert property (@(posedge clk) disable iff (!arst_n)
		take |-> !(pos_busy || spd_busy || pwr_busy))
		else $error("word accepted while a multiplier was still running");

	// Position and speed products are computed in lockstep.
	a_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		pos_busy == spd_busy)
		else $error("position and speed multipliers out of step");

	// The first pass starts all three multipliers together.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_START) |=> (pos_busy && spd_busy && pwr_busy))
		else $error("first multiplier pass did not start");

	// A finished word waits while the output register is held by the receiver.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL2 && out_valid_q && !result.ready) |=> (state_q == S_MUL2))
		else $error("result left the core while the output register was full");

endmodule

@@ dv/multiturn_encoder_feedback_decoder_core_test.sv @@
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// Multi-turn encoder feedback decoder testbench
// Sends feedback words in bursts against a receiver that stalls, and predicts
// every decoded word from its own copy of the per-motor unwrap state and zero
// offsets. Decoded words are checked field by field and in order, across
// several zero-offset settings that include both extremes.
// -----------------------------------------------------------------------------
module multiturn_encoder_feedback_decoder_core_test;
	import mefd_pkg::*;

	localparam int CLK_HALF        = 4;
	localparam int RESET_CYCLES    = 12;
	localparam int RANDOM_PHASES   = 5;
	localparam int PHASE_WORDS     = 266;
	localparam int QUIET_LIMIT     = 4000;
	localparam int DRAIN_CYCLES    = 48;
	localparam int COUNTS_PER_TURN = 8192;
	localparam int ANGLE_TOP       = 65535;

	localparam int REG_OFFSET_0    = 0;
	localparam int REG_OFFSET_1    = 1;
	localparam int REG_OFFSET_2    = 2;
	localparam int REG_OFFSET_3    = 3;

	localparam longint          RAD_PER_COUNT = 64'sd843314842;
	localparam longint          RAD_PER_RPM   = 64'sd449767901;
	localparam longint unsigned POWER_SCALE   = 64'd3999336307;

	localparam logic signed [OFFSET_W-1:0] OFFSET_HIGH = 28'sh7FFFFFF;
	localparam logic signed [OFFSET_W-1:0] OFFSET_LOW  = 28'sh8000000;

	typedef struct packed {
		logic [MOTOR_W-1:0]          motor;
		logic [ANGLE_W-1:0]          angle;
		logic signed [SPEED_W-1:0]   speed;
		logic signed [CURRENT_W-1:0] current;
		logic [TEMP_W-1:0]           temp;
	} frame_word_t;

	typedef struct packed {
		logic [MOTOR_W-1:0]          motor_id;
		logic signed [POS_W-1:0]     position_counts;
		logic signed [POS_RAD_W-1:0] position_rad;
		logic signed [SPD_RAD_W-1:0] speed_rad;
		logic signed [CURRENT_W-1:0] current;
		logic [TEMP_W-1:0]           temp;
		logic [POWER_W-1:0]          power;
	} decoded_word_t;

	typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_COMB, RX_BLOCKED} rx_mode_t;

	logic                 clk;
	logic                 arst_n;
	logic                 wr_en;
	logic [CFG_IDX_W-1:0] wr_index;
	logic [OFFSET_W-1:0]  wr_data;

	mefd_frame_if  frame ();
	mefd_result_if result ();

	multiturn_encoder_feedback_decoder_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.frame    (frame.sink),
		.result   (result.source)
	);

	logic [ANGLE_W-1:0]         last_angle [NUM_MOTORS];
	logic signed [TURN_W-1:0]   turns      [NUM_MOTORS];
	logic                       seen       [NUM_MOTORS];
	logic signed [OFFSET_W-1:0] offsets    [OFFSET_REGS];
	int                         driven_angle [NUM_MOTORS];

	frame_word_t   pending_words [$];
	decoded_word_t awaited_words [$];
	frame_word_t   next_word;
	frame_word_t   taken_word;
	decoded_word_t want;

	int       frames_queued    = 0;
	int       frames_presented = 0;
	int       frames_accepted  = 0;
	int       results_checked  = 0;
	int       errors           = 0;
	int       quiet_cycles     = 0;
	int       turn_steps       = 0;
	int       turn_low         = 0;
	int       turn_high        = 0;
	int       burst_left       = 0;
	int       gap_left         = 0;
	int       stall_span       = 0;
	rx_mode_t stall_mode       = RX_OPEN;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	function automatic decoded_word_t decode_frame(input frame_word_t w);
		decoded_word_t  d;
		longint         angle;
		longint         prev;
		longint         pos;
		longint         pos_rad;
		longint         spd;
		longint         prod;
		longint unsigned mag;
		longint unsigned power;
		pos     = 0;
		pos_rad = 0;
		angle   = longint'(w.angle);
		if (w.motor < NUM_MOTORS) begin
			prev = longint'(last_angle[w.motor]);
			if (seen[w.motor] && angle - prev > JUMP_LIMIT) begin
				if (turns[w.motor] != TURN_MIN) begin
					turns[w.motor] = turns[w.motor] - TURN_W'(1);
					turn_steps++;
				end
			end else if (seen[w.motor] && prev - angle > JUMP_LIMIT) begin
				if (turns[w.motor] != TURN_MAX) begin
					turns[w.motor] = turns[w.motor] + TURN_W'(1);
					turn_steps++;
				end
			end else if (!seen[w.motor]) begin
				seen[w.motor] = 1'b1;
			end
			last_angle[w.motor] = w.angle;
			if (int'(turns[w.motor]) < turn_low) begin
				turn_low = int'(turns[w.motor]);
			end
			if (int'(turns[w.motor]) > turn_high) begin
				turn_high = int'(turns[w.motor]);
			end
			pos = longint'(turns[w.motor]) * COUNTS_PER_TURN + angle;
			if (w.motor < OFFSET_REGS) begin
				pos = pos - longint'(offsets[w.motor[CFG_IDX_W-1:0]]);
			end
			pos_rad = (pos * RAD_PER_COUNT) >>> POS_RAD_LSB;
		end
		spd   = (longint'($signed(w.speed)) * RAD_PER_RPM) >>> SPD_RAD_LSB;
		prod  = longint'($signed(w.speed)) * longint'($signed(w.current));
		mag   = (prod < 0) ? longint'(-prod) : longint'(prod);
		power = (mag * POWER_SCALE) >> POWER_LSB;
		d.motor_id        = w.motor;
		d.position_counts = pos[POS_W-1:0];
		d.position_rad    = pos_rad[POS_RAD_W-1:0];
		d.speed_rad       = spd[SPD_RAD_W-1:0];
		d.current         = w.current;
		d.temp            = w.temp;
		d.power           = power[POWER_W-1:0];
		return d;
	endfunction

	task automatic compare_field(input string name, input logic signed [63:0] exp_val,
			input logic signed [63:0] got_val);
		if (exp_val !== got_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			errors++;
		end
	endtask

	task automatic queue_word(input int motor, input int angle, input int speed,
			input int current, input int temp);
		frame_word_t w;
		w.motor   = MOTOR_W'(motor);
		w.angle   = ANGLE_W'(angle);
		w.speed   = SPEED_W'(speed);
		w.current = CURRENT_W'(current);
		w.temp    = TEMP_W'(temp);
		pending_words.push_back(w);
		frames_queued++;
	endtask

	task automatic queue_random_word();
		int sel;
		int motor;
		int angle;
		int step;
		int speed;
		int current;
		sel     = $urandom_range(0, 99);
		motor   = $urandom_range(0, NUM_MOTORS - 1);
		speed   = $urandom_range(0, ANGLE_TOP) - 32768;
		current = $urandom_range(0, ANGLE_TOP) - 32768;
		angle   = driven_angle[motor];
		if (sel < 60) begin
			angle = (angle + $urandom_range(0, 1400) - 700) & (COUNTS_PER_TURN - 1);
		end else if (sel < 70) begin
			step = $urandom_range(JUMP_LIMIT - 5, JUMP_LIMIT + 5);
			if ($urandom_range(0, 1) == 1) begin
				step = -step;
			end
			if (angle + step < 0 || angle + step > ANGLE_TOP) begin
				step = -step;
			end
			angle = angle + step;
		end else if (sel < 85) begin
			angle = $urandom_range(0, ANGLE_TOP);
		end else if (sel < 93) begin
			motor = NUM_MOTORS;
			angle = $urandom_range(0, ANGLE_TOP);
		end else begin
			angle   = $urandom_range(0, ANGLE_TOP);
			speed   = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
			current = ($urandom_range(0, 1) == 1) ? 32767 : -32768;
		end
		if (motor < NUM_MOTORS) begin
			driven_angle[motor] = angle;
		end
		queue_word(motor, angle, speed, current, $urandom_range(0, 255));
	endtask

	task automatic write_offset(input int idx, input logic signed [OFFSET_W-1:0] value);
		@(negedge clk);
		wr_en        = 1'b1;
		wr_index     = CFG_IDX_W'(idx);
		wr_data      = value;
		offsets[idx] = value;
	endtask

	always @(negedge clk) begin
		if (!arst_n) begin
			frame.valid           <= 1'b0;
			frame.motor_index     <= '0;
			frame.angle_raw       <= '0;
			frame.speed_raw       <= '0;
			frame.current_raw     <= '0;
			frame.temperature_raw <= '0;
		end else if (!frame.valid || frames_accepted == frames_presented) begin
			if (gap_left != 0 || pending_words.size() == 0) begin
				frame.valid <= 1'b0;
				if (gap_left != 0) begin
					gap_left <= gap_left - 1;
				end
			end else begin
				next_word = pending_words.pop_front();
				frame.valid           <= 1'b1;
				frame.motor_index     <= next_word.motor;
				frame.angle_raw       <= next_word.angle;
				frame.speed_raw       <= next_word.speed;
				frame.current_raw     <= next_word.current;
				frame.temperature_raw <= next_word.temp;
				frames_presented      <= frames_presented + 1;
				if (burst_left <= 1) begin
					burst_left <= $urandom_range(1, 24);
					gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 90);
				end else begin
					burst_left <= burst_left - 1;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (stall_span == 0) begin
			stall_mode   <= rx_mode_t'($urandom_range(0, 3));
			stall_span   <= $urandom_range(16, 160);
			result.ready <= 1'b1;
		end else begin
			stall_span <= stall_span - 1;
			case (stall_mode)
				RX_OPEN: begin
					result.ready <= 1'b1;
				end
				RX_RANDOM: begin
					result.ready <= 1'($urandom_range(0, 1));
				end
				RX_COMB: begin
					result.ready <= (stall_span[2:0] == 3'd0);
				end
				default: begin
					result.ready <= 1'b0;
				end
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (result.valid && result.ready) begin
				if (awaited_words.size() == 0) begin
					$error("Decoded word for motor %0d arrived with nothing awaited",
						result.motor_id_out);
					errors++;
				end else begin
					want = awaited_words.pop_front();
					compare_field("motor_id_out", want.motor_id, result.motor_id_out);
					compare_field("position_counts", want.position_counts,
						result.position_counts);
					compare_field("position_rad_q16", want.position_rad,
						result.position_rad_q16);
					compare_field("speed_rad_q16", want.speed_rad, result.speed_rad_q16);
					compare_field("current_out", want.current, result.current_out);
					compare_field("temperature_out", want.temp, result.temperature_out);
					compare_field("power_q16", want.power, result.power_q16);
					results_checked++;
				end
			end
			if (frame.valid && frame.ready) begin
				taken_word.motor   = frame.motor_index;
				taken_word.angle   = frame.angle_raw;
				taken_word.speed   = frame.speed_raw;
				taken_word.current = frame.current_raw;
				taken_word.temp    = frame.temperature_raw;
				awaited_words.push_back(decode_frame(taken_word));
				frames_accepted++;
			end
			if ((frame.valid && frame.ready) || (result.valid && result.ready) || wr_en) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Watchdog expired after %0d cycles without a handshake.", quiet_cycles);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		int                         phase;
		int                         reg_idx;
		int                         n;
		int                         m;
		logic signed [OFFSET_W-1:0] value;
		arst_n   = 1'b0;
		wr_en    = 1'b0;
		wr_index = '0;
		wr_data  = '0;
		for (m = 0; m < NUM_MOTORS; m++) begin
			last_angle[m]   = '0;
			turns[m]        = '0;
			seen[m]         = 1'b0;
			driven_angle[m] = 0;
		end
		for (m = 0; m < OFFSET_REGS; m++) begin
			offsets[m] = '0;
		end
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_offset(REG_OFFSET_0, '0);
		write_offset(REG_OFFSET_1, OFFSET_LOW);
		write_offset(REG_OFFSET_2, OFFSET_HIGH);
		write_offset(REG_OFFSET_3, 28'sd5000);
		@(negedge clk);
		wr_en = 1'b0;

		// Unwrap edges: first words, jumps of exactly the limit and one past it.
		queue_word(0, 0, 0, 0, 0);
		queue_word(0, 8191, 32767, 32767, 255);
		queue_word(0, 0, -32768, -32768, 0);
		queue_word(0, 4000, -1, 1, 1);
		queue_word(0, 8001, 1, -1, 128);
		queue_word(0, 4001, 32767, -32768, 127);
		queue_word(0, 0, -32768, 32767, 254);
		queue_word(1, 65535, -32768, 32767, 85);
		queue_word(1, 0, 12345, -321, 170);
		queue_word(1, 65535, -7, 9, 3);
		queue_word(2, 1234, 100, 200, 40);
		queue_word(3, 8191, -100, 50, 60);
		queue_word(3, 100, 2000, 2000, 70);
		queue_word(4, 3000, 30000, -30000, 80);
		queue_word(5, 0, -1, -1, 90);
		queue_word(5, 60000, 1, 1, 100);
		queue_word(6, 40000, 5, -5, 110);
		queue_word(7, 65535, 32767, -32768, 120);
		queue_word(7, 0, -32768, -32768, 130);
		queue_word(6, 0, 0, 32767, 140);
		queue_word(2, 1234, 32767, 0, 150);
		queue_word(4, 8190, -16384, 16384, 160);

		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait (results_checked == frames_queued);
			for (reg_idx = 0; reg_idx < OFFSET_REGS; reg_idx++) begin
				case (phase)
					0: value = OFFSET_HIGH;
					1: value = OFFSET_LOW;
					2: value = OFFSET_W'($urandom());
					3: value = OFFSET_W'($urandom_range(0, ANGLE_TOP) - 32768);
					default: value = '0;
				endcase
				write_offset(reg_idx, value);
			end
			@(negedge clk);
			wr_en = 1'b0;
			for (n = 0; n < PHASE_WORDS; n++) begin
				queue_random_word();
			end
		end

		wait (results_checked == frames_queued);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (awaited_words.size() != 0) begin
			$error("%0d decoded words never arrived", awaited_words.size());
			errors++;
		end
		$display("Checked %0d decoded words under %0d zero-offset settings, out-of-range motors too.",
			results_checked, RANDOM_PHASES + 1);
		$display("Turn counts ranged from %0d to %0d over %0d wrap steps.",
			turn_low, turn_high, turn_steps);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
design/mefd_pkg.sv
design/mefd_frame_if.sv
design/mefd_result_if.sv
design/mefd_smul.sv
design/mefd_track.sv
design/multiturn_encoder_feedback_decoder_core.sv
dv/multiturn_encoder_feedback_decoder_core_test.sv
